// ===== hw/rtl/permutation_linkage_distance_update_core_assert.svh =====
// Assertion macros for the pair linkage distance core.
// Expects clk and rst_n in the scope of each use.
`ifndef PERMUTATION_LINKAGE_DISTANCE_UPDATE_CORE_ASSERT_SVH
`define PERMUTATION_LINKAGE_DISTANCE_UPDATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

// ===== hw/rtl/pldu_pkg.sv =====
// Shared types and constants of the pair linkage distance core.
// No dependencies.
package pldu_pkg;

  localparam int MAX_GENES_DEF = 64;
  localparam int KEY_BITS_DEF  = 16;
  localparam int ETB_DEF       = 10;

  localparam int KEY_IN_W   = 16;
  localparam int POP_W      = 16;
  localparam int GENE_IDX_W = 6;
  localparam int DIST_W     = 17;
  localparam int CNT_W      = 7;
  localparam int ORDER_W    = 16;
  localparam int SQ_SUM_W   = 48;
  localparam int DIV_W      = 48;

  localparam logic [DIST_W-1:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic [KEY_IN_W-1:0] gene_key;
    logic [POP_W-1:0]    population_size;
  } in_item_t;

  typedef struct packed {
    logic [GENE_IDX_W-1:0] first_gene;
    logic [GENE_IDX_W-1:0] second_gene;
    logic [DIST_W-1:0]     distance;
    logic                  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [POP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pldu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pldu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pldu_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pldu_pkg for the request and response structs.
module pldu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pldu_pkg::div_req_t  req,
  output pldu_pkg::div_rsp_t  rsp
);

  localparam int CNT_DW = $clog2(pldu_pkg::DIV_W);

  logic [pldu_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [pldu_pkg::POP_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [pldu_pkg::POP_W:0]   trial, trial_sub;
  logic [CNT_DW-1:0]          cnt_r;
  logic                       busy_r, done_r, ge;

  always_comb begin
    trial     = {rem_r, quo_r[pldu_pkg::DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    ge        = trial >= {1'b0, dvs_r};
    rem_nxt   = ge ? trial_sub[pldu_pkg::POP_W-1:0] : trial[pldu_pkg::POP_W-1:0];
    quo_nxt   = {quo_r[pldu_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        cnt_r  <= CNT_DW'(pldu_pkg::DIV_W - 1);
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/pldu_rom.sv =====
// Binary entropy table, Q1.16, built at elaboration, registered read.
// Depends on pldu_pkg for the result width.
module pldu_rom #(
  parameter int ETB = 10
) (
  input  logic                          clk,
  input  logic [ETB:0]                  addr,
  output logic [pldu_pkg::DIST_W-1:0]   rdata
);

  localparam int N = 1 << ETB;

  typedef logic [pldu_pkg::DIST_W-1:0] tbl_t [0:N];

  // log2 with 16 fraction bits by repeated squaring, truncated
  function automatic logic [63:0] log2_q16(logic [63:0] k);
    logic [63:0] n, y, r;
    n = '0;
    for (int s = 0; s < 40; s++) begin
      if (n == 64'(s) && (k >> (s + 1)) != '0) begin
        n = 64'(s + 1);
      end
    end
    y = k << (64'd31 - n);
    r = n << 16;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y    = y >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] entropy_point(logic [63:0] k);
    logic [63:0] full, s, h;
    full = 64'(ETB) << 16;
    if (k == '0 || k >= 64'(N)) begin
      return '0;
    end
    s = k * (full - log2_q16(k)) + (64'(N) - k) * (full - log2_q16(64'(N) - k));
    h = (s + 64'(N / 2)) >> ETB;
    return (h > 64'h10000) ? 64'h10000 : h;
  endfunction

  function automatic tbl_t build_table();
    tbl_t t;
    for (int k = 0; k <= N; k++) begin
      t[k] = pldu_pkg::DIST_W'(entropy_point(64'(k)));
    end
    return t;
  endfunction

  localparam tbl_t TABLE = build_table();

  logic [pldu_pkg::DIST_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    rdata_r <= TABLE[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/permutation_linkage_distance_update_core.sv =====
// Pair linkage distance core: accepts one gene key per transaction and emits one
// distance per earlier gene. Each pair runs two passes of the shared serial divider
// plus table and multiplier steps. After reset a clearing pass over all
// MAX_GENES*MAX_GENES pair addresses zeroes the pair sums; no transaction is
// accepted meanwhile, configuration writes are.
`include "permutation_linkage_distance_update_core_assert.svh"
module permutation_linkage_distance_update_core #(
  parameter int MAX_GENES = pldu_pkg::MAX_GENES_DEF,
  parameter int KEY_BITS  = pldu_pkg::KEY_BITS_DEF,
  parameter int ETB       = pldu_pkg::ETB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pldu_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pldu_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [pldu_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int POS_W    = $clog2(MAX_GENES);
  localparam int PAIRS    = MAX_GENES * MAX_GENES;
  localparam int PAIR_W   = $clog2(PAIRS);
  localparam int KEY_W    = (KEY_BITS < pldu_pkg::KEY_IN_W) ? KEY_BITS : pldu_pkg::KEY_IN_W;
  localparam int A_SHIFT  = 2 * KEY_BITS - 16;
  localparam int SUM_W    = pldu_pkg::ORDER_W + pldu_pkg::SQ_SUM_W;
  localparam int FRAC_SH  = 16 - ETB;
  localparam int CW       = pldu_pkg::CNT_W;
  localparam int DW       = pldu_pkg::DIST_W;
  localparam int MW       = 2 * DW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_UPD, S_SUM, S_DIVP, S_DIVA,
    S_ROM0, S_ROM1, S_ROM2, S_MUL1, S_MUL2, S_FIN, S_OUT
  } state_t;

  state_t                           state_r;
  logic [PAIR_W-1:0]                clr_addr_r;
  logic [CW-1:0]                    gene_count_r;
  logic [POS_W-1:0]                 pos_r, j_r, i_r;
  logic [KEY_W-1:0]                 key_r;
  logic [pldu_pkg::POP_W-1:0]       pop_r;
  logic                             lt_r, up_r;
  logic [pldu_pkg::ORDER_W-1:0]     order_r;
  logic [pldu_pkg::SQ_SUM_W-1:0]    sq_sum_r;
  logic [MW-1:0]                    mul_r;
  logic [DW-1:0]                    p_r, a_r, t0_r, h_r;
  logic                             out_valid_r;
  pldu_pkg::out_item_t              out_data_r;

  logic                             accept;
  logic [CW-1:0]                    cnt_clamp, pos_inc;
  logic [POS_W-1:0]                 j_nxt, pos_nxt;
  logic [KEY_W-1:0]                 key_in, key_rd, d;
  logic [PAIR_W-1:0]                pair_addr;
  logic [SUM_W-1:0]                 sum_rd;
  logic                             sum_we;
  logic [PAIR_W-1:0]                sum_waddr;
  logic [SUM_W-1:0]                 sum_wdata;
  logic [pldu_pkg::SQ_SUM_W:0]      sq_add;
  logic [pldu_pkg::SQ_SUM_W-1:0]    sq_sum_nxt;
  logic [pldu_pkg::ORDER_W-1:0]     order_nxt;
  pldu_pkg::div_req_t               div_req;
  pldu_pkg::div_rsp_t               div_rsp;
  logic [pldu_pkg::DIV_W-1:0]       a_big;
  logic [DW-1:0]                    p_clamp, a_clamp;
  logic [ETB:0]                     rom_k, rom_addr;
  logic [DW-1:0]                    rom_q, diff, h_nxt;
  logic [15:0]                      frac;
  logic [DW-1:0]                    mul_a, mul_b;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (gene_count_r < CW'(2)) begin
      cnt_clamp = CW'(2);
    end else if (gene_count_r > CW'(MAX_GENES)) begin
      cnt_clamp = CW'(MAX_GENES);
    end else begin
      cnt_clamp = gene_count_r;
    end
    j_nxt   = (CW'(pos_r) >= cnt_clamp) ? '0 : pos_r;
    pos_inc = CW'(j_nxt) + CW'(1);
    pos_nxt = (pos_inc >= cnt_clamp) ? '0 : POS_W'(pos_inc);
  end

  assign key_in    = in_data.gene_key[KEY_W-1:0];
  assign pair_addr = PAIR_W'(PAIR_W'(i_r) * PAIR_W'(MAX_GENES) + PAIR_W'(j_r));

  pldu_ram #(.WIDTH(KEY_W), .DEPTH(MAX_GENES)) u_key_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (j_nxt),
    .wdata (key_in),
    .raddr (i_r),
    .rdata (key_rd)
  );

  // pair sum update with saturation
  always_comb begin
    sq_add     = {1'b0, sq_sum_r} + (pldu_pkg::SQ_SUM_W + 1)'(mul_r[2*KEY_W-1:0]);
    sq_sum_nxt = sq_add[pldu_pkg::SQ_SUM_W] ? '1 : sq_add[pldu_pkg::SQ_SUM_W-1:0];
    order_nxt  = (lt_r && order_r != '1) ? order_r + 1'b1 : order_r;
    sum_we     = (state_r == S_CLR) || (state_r == S_SUM);
    sum_waddr  = (state_r == S_CLR) ? clr_addr_r : pair_addr;
    sum_wdata  = (state_r == S_CLR) ? '0 : {order_nxt, sq_sum_nxt};
  end

  pldu_ram #(.WIDTH(SUM_W), .DEPTH(PAIRS)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (pair_addr),
    .rdata (sum_rd)
  );

  always_comb begin
    div_req.start    = (state_r == S_SUM) || (state_r == S_DIVP && div_rsp.done);
    div_req.dividend = (state_r == S_SUM) ?
                       pldu_pkg::DIV_W'({order_nxt, 16'h0}) : sq_sum_r;
    div_req.divisor  = pop_r;
  end

  pldu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    p_clamp = (div_rsp.quotient > pldu_pkg::DIV_W'(pldu_pkg::Q16_ONE)) ?
              pldu_pkg::Q16_ONE : div_rsp.quotient[DW-1:0];
    a_big   = div_rsp.quotient >> A_SHIFT;
    a_clamp = (a_big > pldu_pkg::DIV_W'(pldu_pkg::Q16_ONE)) ?
              pldu_pkg::Q16_ONE : a_big[DW-1:0];
  end

  // entropy lookup: entry k, then k+1, interpolate on the fraction
  always_comb begin
    rom_k    = (ETB + 1)'(p_r >> FRAC_SH);
    rom_addr = (state_r == S_ROM1) ? rom_k + 1'b1 : rom_k;
    frac     = 16'(p_r << ETB);
    diff     = (rom_q >= t0_r) ? rom_q - t0_r : t0_r - rom_q;
    if (rom_k[ETB]) begin
      h_nxt = '0;
    end else if (up_r) begin
      h_nxt = t0_r + mul_r[DW+15:16];
    end else begin
      h_nxt = t0_r - mul_r[DW+15:16];
    end
  end

  pldu_rom #(.ETB(ETB)) u_rom (
    .clk   (clk),
    .addr  (rom_addr),
    .rdata (rom_q)
  );

  // shared multiplier operands
  always_comb begin
    d = (key_rd > key_r) ? key_rd - key_r : key_r - key_rd;
    case (state_r)
      S_UPD: begin
        mul_a = DW'(d);
        mul_b = DW'(d);
      end
      S_ROM2: begin
        mul_a = diff;
        mul_b = DW'(frac);
      end
      default: begin
        mul_a = pldu_pkg::Q16_ONE - h_r;
        mul_b = pldu_pkg::Q16_ONE - a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      gene_count_r <= CW'(MAX_GENES);
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        gene_count_r <= cfg_wdata;
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == PAIR_W'(PAIRS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            j_r     <= j_nxt;
            pos_r   <= pos_nxt;
            key_r   <= key_in;
            pop_r   <= (in_data.population_size == '0) ? 16'd1 : in_data.population_size;
            i_r     <= '0;
            state_r <= (j_nxt == '0) ? S_IDLE : S_RD;
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          lt_r     <= key_rd < key_r;
          order_r  <= sum_rd[SUM_W-1:pldu_pkg::SQ_SUM_W];
          sq_sum_r <= sum_rd[pldu_pkg::SQ_SUM_W-1:0];
          state_r  <= S_SUM;
        end
        S_SUM: begin
          sq_sum_r <= sq_sum_nxt;
          state_r  <= S_DIVP;
        end
        S_DIVP: begin
          if (div_rsp.done) begin
            p_r     <= p_clamp;
            state_r <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_rsp.done) begin
            a_r     <= a_clamp;
            state_r <= S_ROM0;
          end
        end
        S_ROM0: state_r <= S_ROM1;
        S_ROM1: begin
          t0_r    <= rom_q;
          state_r <= S_ROM2;
        end
        S_ROM2: begin
          up_r    <= rom_q >= t0_r;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          h_r     <= h_nxt;
          state_r <= S_MUL2;
        end
        S_MUL2: state_r <= S_FIN;
        S_FIN: begin
          out_data_r.first_gene  <= pldu_pkg::GENE_IDX_W'(i_r);
          out_data_r.second_gene <= pldu_pkg::GENE_IDX_W'(j_r);
          out_data_r.distance    <= pldu_pkg::Q16_ONE - mul_r[DW+15:16];
          out_data_r.last_of_run <= (i_r + 1'b1 == j_r);
          out_valid_r            <= 1'b1;
          state_r                <= S_OUT;
        end
        S_OUT: begin
          // hold until the transaction is taken, then advance to the next pair or return to idle
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (i_r + 1'b1 == j_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_in_only_when_drained, in_valid && !in_stall, !out_valid_r)
  `ASSERT_IMPLIES(a_pair_order, out_valid_r, out_data_r.first_gene < out_data_r.second_gene)
  `ASSERT_IMPLIES(a_distance_range, out_valid_r, out_data_r.distance <= pldu_pkg::Q16_ONE)
  `ASSERT_ALWAYS(a_div_start_idle, !(div_req.start && div_rsp.busy))

endmodule

// ===== dv/tb_permutation_linkage_distance_update_core.sv =====
// Testbench of the pair linkage distance core: drives gene keys, predicts every pair
// distance from its own copy of keys and pair sums, and checks each result transaction.
// Depends on pldu_pkg and permutation_linkage_distance_update_core.
module tb_permutation_linkage_distance_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GENES = 64;
  localparam int LIMIT = 200000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  pldu_pkg::in_item_t in_data;
  pldu_pkg::out_item_t out_data;
  logic [pldu_pkg::CNT_W-1:0] cfg_wdata;

  permutation_linkage_distance_update_core u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_wdata
  );

  // predictor state
  logic [15:0] keys [GENES];
  logic [15:0] order_sum [GENES*GENES];
  logic [47:0] sqdiff_sum [GENES*GENES];
  int unsigned position;
  logic [pldu_pkg::CNT_W-1:0] gene_count;
  pldu_pkg::out_item_t pending_distances[$];
  int errors;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned log2_fix(longint unsigned k);
    longint unsigned n, y, r;
    n = 0;
    while (n < 40 && (k >> (n + 1)) != 0) n++;
    y = k << (31 - n);
    r = n << 16;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 31;
      if (y >= (64'd2 << 31)) begin
        y >>= 1;
        r |= 64'd1 << b;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned entropy_entry(longint unsigned k);
    longint unsigned s, h;
    if (k == 0 || k >= 1024) return 0;
    s = k * ((64'd10 << 16) - log2_fix(k)) + (1024 - k) * ((64'd10 << 16) - log2_fix(1024 - k));
    h = (s + 512) >> 10;
    return h > 65536 ? 65536 : h;
  endfunction

  function automatic longint unsigned entropy(longint unsigned p);
    longint unsigned k, fr, t0, t1;
    k = (p << 10) >> 16;
    fr = (p << 10) & 16'hFFFF;
    if (k >= 1024) return 0;
    t0 = entropy_entry(k);
    t1 = entropy_entry(k + 1);
    if (t1 >= t0) return t0 + (((t1 - t0) * fr) >> 16);
    return t0 - (((t0 - t1) * fr) >> 16);
  endfunction

  function automatic void predict_pairs(pldu_pkg::in_item_t it);
    longint unsigned cnt, pop, ki, key, d, sq, p, a, h, m;
    int unsigned j, idx;
    pldu_pkg::out_item_t r;
    cnt = gene_count;
    if (cnt < 2) cnt = 2;
    if (cnt > GENES) cnt = GENES;
    pop = it.population_size == 0 ? 1 : it.population_size;
    key = it.gene_key;
    if (position >= cnt) position = 0;
    j = position;
    keys[j] = it.gene_key;
    for (int unsigned i = 0; i < j; i++) begin
      idx = i * GENES + j;
      ki = keys[i];
      d = ki > key ? ki - key : key - ki;
      sq = d * d;
      if (ki < key && order_sum[idx] != 16'hFFFF) order_sum[idx]++;
      if (48'hFFFF_FFFF_FFFF - sqdiff_sum[idx] < sq) sqdiff_sum[idx] = '1;
      else sqdiff_sum[idx] = sqdiff_sum[idx] + sq;
      p = (64'(order_sum[idx]) << 16) / pop;
      if (p > 65536) p = 65536;
      a = (64'(sqdiff_sum[idx]) / pop) >> 16;
      if (a > 65536) a = 65536;
      h = entropy(p);
      m = ((65536 - h) * (65536 - a)) >> 16;
      r.first_gene = i[5:0];
      r.second_gene = j[5:0];
      r.distance = 17'(65536 - m);
      r.last_of_run = (i + 1 == j);
      pending_distances.insert(pending_distances.size(), r);
    end
    position = j + 1;
    if (position >= cnt) position = 0;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_gene(logic [15:0] key, logic [15:0] pop);
    int gap;
    gap = short_or_long_gap();
    repeat (gap) @(negedge clk);
    in_data.gene_key = key;
    in_data.population_size = pop;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_pairs(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // drain and settle before touching the register
  task automatic write_gene_count(logic [pldu_pkg::CNT_W-1:0] value);
    while (pending_distances.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    gene_count = value;
  endtask

  // checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        pldu_pkg::out_item_t e;
        e = pending_distances.pop_front();
        if (out_data.first_gene !== e.first_gene) begin
          $display("%0t: first_gene exp %0d got %0d", $time, e.first_gene, out_data.first_gene);
          errors++;
        end
        if (out_data.second_gene !== e.second_gene) begin
          $display("%0t: second_gene exp %0d got %0d", $time, e.second_gene,
                   out_data.second_gene);
          errors++;
        end
        if (out_data.distance !== e.distance) begin
          $display("%0t: distance exp %0d got %0d", $time, e.distance, out_data.distance);
          errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $display("%0t: last_of_run exp %0b got %0b", $time, e.last_of_run,
                   out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = short_or_long_gap();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    send_gene(16'h0000, 16'd1);
    send_gene(16'hFFFF, 16'd0);
    send_gene(16'h0000, 16'hFFFF);
    send_gene(16'h8000, 16'd1);
    send_gene(16'h7FFF, 16'd2);
    send_gene(16'hAAAA, 16'h5555);
    send_gene(16'h5555, 16'hAAAA);
  endtask

  task automatic test_small_count_saturation();
    // count 2: pair (0,1) hit repeatedly, population 1 pushes both measures to one
    write_gene_count(7'd2);
    for (int n = 0; n < 8; n++) begin
      send_gene(16'h0000, 16'd1);
      send_gene(16'hFFFF, n[0] ? 16'd0 : 16'd1);
    end
  endtask

  task automatic test_count_clamp_low();
    write_gene_count(7'd0);
    for (int n = 0; n < 4; n++) send_gene(16'($urandom), 16'($urandom_range(1, 4)));
    write_gene_count(7'd1);
    for (int n = 0; n < 3; n++) send_gene(16'($urandom), 16'($urandom_range(1, 4)));
  endtask

  task automatic test_count_clamp_high_and_lower();
    write_gene_count(7'd127);
    for (int n = 0; n < 5; n++) send_gene(16'($urandom), 16'($urandom));
    // position now past the new count, so the next gene restarts at zero
    write_gene_count(7'd3);
    for (int n = 0; n < 6; n++) send_gene(16'($urandom), 16'($urandom_range(1, 3)));
  endtask

  task automatic test_random_genes(int items);
    logic [15:0] pop;
    int sel;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        sel = $urandom_range(0, 3);
        write_gene_count(sel == 0 ? 7'd64 : sel == 1 ? 7'd2 : 7'($urandom_range(3, 12)));
      end
      case ($urandom_range(0, 3))
        0: pop = 16'($urandom);
        1: pop = 16'($urandom_range(0, 8));
        default: pop = 16'($urandom_range(1, 64));
      endcase
      send_gene(16'($urandom), pop);
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    gene_count = 7'd64;
    position = 0;
    foreach (keys[k]) keys[k] = '0;
    foreach (order_sum[k]) begin
      order_sum[k] = '0;
      sqdiff_sum[k] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_small_count_saturation();
    test_count_clamp_low();
    test_count_clamp_high_and_lower();
    test_random_genes(140);
    while (pending_distances.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
